/* sv/ppc_pkg.sv */
package ppc_pkg;

  // Field widths.
  localparam int ADC_W      = 12;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 14;

  // Serial arithmetic units.
  localparam int DIV_W      = 28;
  localparam int DVS_W      = 14;
  localparam int MUL_W      = 15;
  localparam int PROD_W     = 2 * MUL_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_OUTPUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_LEVELS = 3'd7;

  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_LOG    = 2'd1;
  localparam logic [1:0] CURVE_EXP    = 2'd2;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* sv/ppc_in_if.sv */
interface ppc_in_if;
  logic                       valid;
  logic                       ready;
  logic [ppc_pkg::ADC_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* sv/ppc_out_if.sv */
interface ppc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       send;
  logic [ppc_pkg::VAL_W-1:0]  out_level;
  logic [ppc_pkg::POS_W-1:0]  position;
  logic [ppc_pkg::ADC_W-1:0]  smoothed;
  logic                       toe_event;
  logic                       heel_event;
  logic                       activity;

  modport source (output valid, output send, output out_level, output position,
                  output smoothed, output toe_event, output heel_event,
                  output activity, input ready);
  modport sink   (input valid, input send, input out_level, input position,
                  input smoothed, input toe_event, input heel_event,
                  input activity, output ready);
endinterface

/* sv/ppc_div.sv */
// Restoring divider, one quotient bit per cycle.
module ppc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppc_pkg::DIV_W-1:0]     dividend,
  input  logic [ppc_pkg::DVS_W-1:0]     divisor,
  output logic [ppc_pkg::DIV_W-1:0]     quotient,
  output ppc_pkg::unit_stat_t           stat
);
  localparam int CNT_W = $clog2(ppc_pkg::DIV_W);

  logic [ppc_pkg::DIV_W-1:0] q;
  logic [ppc_pkg::DVS_W-1:0] rem;
  logic [ppc_pkg::DVS_W-1:0] dvs;
  logic [CNT_W-1:0]          cnt;
  logic                      run;
  logic                      done;
  logic [ppc_pkg::DVS_W:0]   trial;
  logic                      fits;

  assign trial = {rem, q[ppc_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ppc_pkg::DIV_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      q   <= {q[ppc_pkg::DIV_W-2:0], fits};
      rem <= fits ? ppc_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[ppc_pkg::DVS_W-1:0];
    end
  end

  assign quotient  = q;
  assign stat.busy = run;
  assign stat.done = done;

endmodule

/* sv/ppc_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle.
module ppc_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppc_pkg::MUL_W-1:0]     a,
  input  logic [ppc_pkg::MUL_W-1:0]     b,
  output logic [ppc_pkg::PROD_W-1:0]    product,
  output ppc_pkg::unit_stat_t           stat
);
  localparam int CNT_W = $clog2(ppc_pkg::MUL_W);

  logic [ppc_pkg::PROD_W-1:0] acc;
  logic [ppc_pkg::PROD_W-1:0] mcand;
  logic [ppc_pkg::MUL_W-1:0]  mplier;
  logic [CNT_W-1:0]           cnt;
  logic                       run;
  logic                       done;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ppc_pkg::MUL_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= ppc_pkg::PROD_W'(a);
      mplier <= b;
    end else if (run) begin
      acc    <= acc + (mplier[0] ? mcand : '0);
      mcand  <= {mcand[ppc_pkg::PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[ppc_pkg::MUL_W-1:1]};
    end
  end

  assign product   = acc;
  assign stat.busy = run;
  assign stat.done = done;

endmodule

/* sv/pedal_position_conditioner_core.sv */
// Pedal position conditioner. Each word on the samples channel is one averaged
// 12-bit ADC reading of an expression pedal; each produces exactly one result
// word with the EMA-filtered value, the 7-bit position, the scaled output value,
// a send flag when that value changed, toe and heel crossing events and an
// activity flag. The block works on one sample at a time. The work per sample
// is set by one bit-serial divider (up to three divisions: EMA, calibration
// mapping, range scaling) and one bit-serial multiplier (up to three products:
// two curve squares and the range scale). A pedal at an end point with the full
// output range takes the shortest path, a log or exp curve with a scaled range
// the longest. A finished result waits in an output register, so the next
// sample may be taken while it is still pending. Configuration registers are
// written through cfg_we, cfg_index and cfg_data and should only change while
// no sample is in flight.
module pedal_position_conditioner_core (
  input  logic                              clk,
  input  logic                              rst,
  ppc_in_if.sink                            samples,
  ppc_out_if.source                         results,
  input  logic                              cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMA   = 4'd1;
  localparam logic [3:0] S_MAP   = 4'd2;
  localparam logic [3:0] S_CURVE = 4'd3;
  localparam logic [3:0] S_SQC   = 4'd4;
  localparam logic [3:0] S_SQF   = 4'd5;
  localparam logic [3:0] S_RNG   = 4'd6;
  localparam logic [3:0] S_RMUL  = 4'd7;
  localparam logic [3:0] S_RDIV  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  // Configuration registers.
  logic [11:0] cal_low, cal_high;
  logic [1:0]  curve_mode;
  logic        reverse, fine_output;
  logic [6:0]  range_low, range_high;
  logic [13:0] switch_levels;

  // Filter and event state.
  logic [11:0] ema_value, stable_value;
  logic        seeded;
  logic [13:0] last_output;
  logic        output_known;
  logic [6:0]  act_anchor;
  logic        act_anchor_valid;
  logic        toe_ready, heel_ready, sw_started;

  // Sequencer and working registers.
  logic [3:0]  state, state_next;
  logic [10:0] nc;
  logic [14:0] nfn;
  logic [20:0] sqc;
  logic [6:0]  pos_r;
  logic [13:0] fine_r;
  logic [13:0] val_r;
  logic        res_valid;
  logic        commit;

  // Arithmetic units.
  logic                          div_start, mul_start;
  logic [ppc_pkg::DIV_W-1:0]     div_a, div_q;
  logic [ppc_pkg::DVS_W-1:0]     div_b;
  logic [ppc_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic [ppc_pkg::PROD_W-1:0]    mul_p;
  ppc_pkg::unit_stat_t           div_st, mul_st;

  ppc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .stat(div_st)
  );

  ppc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .product(mul_p), .stat(mul_st)
  );

  // EMA numerator: 100 * ema + alpha * (sample - ema), with alpha 90 for a
  // jump of more than 50 counts and 5 otherwise. The first sample seeds it.
  logic [11:0] e_base, d1;
  logic        s_ge;
  logic [18:0] d1x, ex, ad, base100, ema_num;

  always_comb begin
    e_base  = seeded ? ema_value : samples.sample;
    s_ge    = samples.sample >= e_base;
    d1      = s_ge ? samples.sample - e_base : e_base - samples.sample;
    d1x     = 19'(d1);
    ex      = 19'(e_base);
    ad      = (d1 > 12'd50) ? (d1x << 6) + (d1x << 4) + (d1x << 3) + (d1x << 1)
                            : (d1x << 2) + d1x;
    base100 = (ex << 6) + (ex << 5) + (ex << 2);
    ema_num = s_ge ? base100 + ad : base100 - ad;
  end

  // Dead band on the new filter value. It is released at or beyond an end
  // point so that the ends are always reachable.
  logic [11:0] ema_new, d2, hyst, f_new;
  logic        release_db, at_low, at_high;

  always_comb begin
    ema_new    = div_q[11:0];
    d2         = (ema_new > stable_value) ? ema_new - stable_value
                                          : stable_value - ema_new;
    hyst       = fine_output ? 12'd4 : 12'd16;
    release_db = (d2 >= hyst) || (ema_new <= cal_low) || (ema_new >= cal_high);
    f_new      = release_db ? ema_new : stable_value;
    at_low     = f_new <= cal_low;
    at_high    = f_new >= cal_high;
  end

  // Normalized position: the divider yields n scaled to 16384; the coarse
  // scale to 1024 is its upper ten bits.
  logic [13:0] nf;
  logic [10:0] nc_w, ac;
  logic [14:0] nfn_w, af;

  always_comb begin
    nf    = div_q[13:0];
    nc_w  = reverse ? 11'd1024 - {1'b0, nf[13:4]} : {1'b0, nf[13:4]};
    nfn_w = reverse ? 15'd16384 - {1'b0, nf} : {1'b0, nf};
    ac    = (curve_mode == ppc_pkg::CURVE_LOG) ? 11'd1024 - nc : nc;
    af    = (curve_mode == ppc_pkg::CURVE_LOG) ? 15'd16384 - nfn : nfn;
  end

  // Curve results. Codes other than log and exp are linear.
  logic [17:0] lin_x;
  logic [27:0] sqc_x;
  logic [7:0]  tc, pc;
  logic [14:0] tf, pf;
  logic [6:0]  pos_lin, pos_curve;
  logic [13:0] fine_lin, fine_curve;

  always_comb begin
    lin_x      = (18'(nc) << 7) - 18'(nc);
    pos_lin    = lin_x[16:10];
    fine_lin   = (nfn > 15'd16383) ? 14'd16383 : nfn[13:0];
    sqc_x      = (28'(sqc) << 7) - 28'(sqc);
    tc         = sqc_x[27:20];
    pc         = (curve_mode == ppc_pkg::CURVE_LOG) ? 8'd127 - tc : tc;
    pos_curve  = (pc > 8'd127) ? 7'd127 : pc[6:0];
    tf         = mul_p[28:14];
    pf         = (curve_mode == ppc_pkg::CURVE_LOG) ? 15'd16384 - tf : tf;
    fine_curve = (pf > 15'd16383) ? 14'd16383 : pf[13:0];
  end

  // Range scaling, done in sign and magnitude: the magnitude of the product
  // is rounded half away from zero and then added to or taken from the low end.
  function automatic logic [13:0] end14(input logic [6:0] e);
    end14 = (e == 7'd127) ? 14'd16383 : {e, 7'b0};
  endfunction

  logic        full_range, neg;
  logic [7:0]  sc;
  logic [6:0]  mag_c;
  logic [13:0] lo_f, hi_f, mag_f, mag, vsel;
  logic [14:0] sf;
  logic [6:0]  val_c;
  logic [13:0] val_f;

  always_comb begin
    full_range = (range_low == 7'd0) && (range_high == 7'd127);
    sc         = {1'b0, range_high} - {1'b0, range_low};
    mag_c      = sc[7] ? 7'(-sc) : sc[6:0];
    lo_f       = end14(range_low);
    hi_f       = end14(range_high);
    sf         = {1'b0, hi_f} - {1'b0, lo_f};
    mag_f      = sf[14] ? 14'(-sf) : sf[13:0];
    neg        = fine_output ? sf[14] : sc[7];
    mag        = fine_output ? mag_f : 14'(mag_c);
    vsel       = fine_output ? fine_r : 14'(pos_r);
    val_c      = neg ? range_low - div_q[6:0] : range_low + div_q[6:0];
    val_f      = neg ? lo_f - div_q[13:0] : lo_f + div_q[13:0];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_a      = '0;
    div_b      = '0;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (samples.valid) begin
          div_start  = 1'b1;
          div_a      = ppc_pkg::DIV_W'(ema_num);
          div_b      = ppc_pkg::DVS_W'(100);
          state_next = S_EMA;
        end
      end
      S_EMA: begin
        if (div_st.done) begin
          if (at_low || at_high) begin
            state_next = S_RNG;
          end else begin
            div_start  = 1'b1;
            div_a      = ppc_pkg::DIV_W'({f_new - cal_low, 14'b0});
            div_b      = ppc_pkg::DVS_W'(cal_high - cal_low);
            state_next = S_MAP;
          end
        end
      end
      S_MAP: begin
        if (div_st.done) begin
          state_next = S_CURVE;
        end
      end
      S_CURVE: begin
        if (curve_mode == ppc_pkg::CURVE_LOG || curve_mode == ppc_pkg::CURVE_EXP) begin
          mul_start  = 1'b1;
          mul_a      = ppc_pkg::MUL_W'(ac);
          mul_b      = ppc_pkg::MUL_W'(ac);
          state_next = S_SQC;
        end else begin
          state_next = S_RNG;
        end
      end
      S_SQC: begin
        if (mul_st.done) begin
          mul_start  = 1'b1;
          mul_a      = af;
          mul_b      = af;
          state_next = S_SQF;
        end
      end
      S_SQF: begin
        if (mul_st.done) begin
          state_next = S_RNG;
        end
      end
      S_RNG: begin
        if (full_range) begin
          state_next = S_FIN;
        end else begin
          mul_start  = 1'b1;
          mul_a      = ppc_pkg::MUL_W'(vsel);
          mul_b      = ppc_pkg::MUL_W'(mag);
          state_next = S_RMUL;
        end
      end
      S_RMUL: begin
        if (mul_st.done) begin
          div_start  = 1'b1;
          div_a      = ppc_pkg::DIV_W'(mul_p) +
                       (fine_output ? ppc_pkg::DIV_W'(8191) : ppc_pkg::DIV_W'(63));
          div_b      = fine_output ? ppc_pkg::DVS_W'(16383) : ppc_pkg::DVS_W'(127);
          state_next = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_st.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!res_valid || results.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign samples.ready = (state == S_IDLE);
  assign commit        = (state == S_FIN) && (!res_valid || results.ready);

  // Result of the final step: send, activity and switch events.
  logic [6:0]  moved;
  logic        act_hit, send_w, toe_hit, heel_hit, toe_arm, heel_arm;
  logic [6:0]  toe_lvl, heel_lvl;
  logic [7:0]  pos8, heel8;

  always_comb begin
    moved    = (pos_r > act_anchor) ? pos_r - act_anchor : act_anchor - pos_r;
    act_hit  = act_anchor_valid && (moved >= 7'd4);
    send_w   = !output_known || (last_output != val_r);
    toe_lvl  = switch_levels[13:7];
    heel_lvl = switch_levels[6:0];
    pos8     = {1'b0, pos_r} + 8'd8;
    heel8    = {1'b0, heel_lvl} + 8'd8;
    toe_arm  = pos8 < {1'b0, toe_lvl};
    heel_arm = {1'b0, pos_r} > heel8;
    toe_hit  = sw_started && toe_ready && (pos_r >= toe_lvl);
    heel_hit = sw_started && heel_ready && (pos_r <= heel_lvl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      res_valid        <= 1'b0;
      cal_low          <= 12'd80;
      cal_high         <= 12'd3900;
      curve_mode       <= ppc_pkg::CURVE_LINEAR;
      reverse          <= 1'b0;
      fine_output      <= 1'b0;
      range_low        <= 7'd0;
      range_high       <= 7'd127;
      switch_levels    <= 14'd15367;
      ema_value        <= '0;
      seeded           <= 1'b0;
      stable_value     <= '0;
      last_output      <= '0;
      output_known     <= 1'b0;
      act_anchor       <= '0;
      act_anchor_valid <= 1'b0;
      toe_ready        <= 1'b0;
      heel_ready       <= 1'b0;
      sw_started       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          ppc_pkg::REG_CAL_LOW:       cal_low       <= cfg_data[11:0];
          ppc_pkg::REG_CAL_HIGH:      cal_high      <= cfg_data[11:0];
          ppc_pkg::REG_CURVE_MODE:    curve_mode    <= cfg_data[1:0];
          ppc_pkg::REG_REVERSE:       reverse       <= cfg_data[0];
          ppc_pkg::REG_FINE_OUTPUT:   fine_output   <= cfg_data[0];
          ppc_pkg::REG_RANGE_LOW:     range_low     <= cfg_data[6:0];
          ppc_pkg::REG_RANGE_HIGH:    range_high    <= cfg_data[6:0];
          ppc_pkg::REG_SWITCH_LEVELS: switch_levels <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_EMA && div_st.done) begin
        ema_value    <= ema_new;
        seeded       <= 1'b1;
        stable_value <= f_new;
      end

      // A new result word replaces the one leaving in the same cycle.
      if (commit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (commit) begin
        last_output  <= val_r;
        output_known <= 1'b1;
        if (!act_anchor_valid || act_hit) begin
          act_anchor <= pos_r;
        end
        act_anchor_valid <= 1'b1;
        sw_started       <= 1'b1;
        if (!sw_started) begin
          toe_ready  <= toe_arm;
          heel_ready <= heel_arm;
        end else begin
          if (toe_hit) begin
            toe_ready <= 1'b0;
          end else if (!toe_ready && toe_arm) begin
            toe_ready <= 1'b1;
          end
          if (heel_hit) begin
            heel_ready <= 1'b0;
          end else if (!heel_ready && heel_arm) begin
            heel_ready <= 1'b1;
          end
        end
      end
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    case (state)
      S_EMA: begin
        if (div_st.done) begin
          if (at_low) begin
            pos_r  <= reverse ? 7'd127 : 7'd0;
            fine_r <= reverse ? 14'd16383 : 14'd0;
          end else if (at_high) begin
            pos_r  <= reverse ? 7'd0 : 7'd127;
            fine_r <= reverse ? 14'd0 : 14'd16383;
          end
        end
      end
      S_MAP: begin
        if (div_st.done) begin
          nc  <= nc_w;
          nfn <= nfn_w;
        end
      end
      S_CURVE: begin
        pos_r  <= pos_lin;
        fine_r <= fine_lin;
      end
      S_SQC: begin
        if (mul_st.done) begin
          sqc <= mul_p[20:0];
        end
      end
      S_SQF: begin
        if (mul_st.done) begin
          pos_r  <= pos_curve;
          fine_r <= fine_curve;
        end
      end
      S_RNG: begin
        val_r <= fine_output ? fine_r : 14'(pos_r);
      end
      S_RDIV: begin
        if (div_st.done) begin
          val_r <= fine_output ? val_f : 14'(val_c);
        end
      end
      default: ;
    endcase

    if (commit) begin
      results.send       <= send_w;
      results.out_level  <= val_r;
      results.position   <= pos_r;
      results.smoothed   <= ema_value;
      results.toe_event  <= toe_hit;
      results.heel_event <= heel_hit;
      results.activity   <= act_hit;
    end
  end

  assign results.valid = res_valid;

  // Assertions.
  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_st.busy)
    else $error("multiplier started while busy");

  a_accept_starts_ema: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> (state == S_EMA && div_st.busy))
    else $error("accepted sample did not start the filter division");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == S_FIN)
    else $error("result word raised outside the final step");

endmodule
